// ----- design/bpe_pkg.sv -----
// shared types and constants for the bivariate polynomial evaluator
// no dependencies

package bpe_pkg;

  localparam int unsigned CoordW = 16;   // Q1.15 coordinate
  localparam int unsigned PowW   = 17;   // power product, one bit above Q1.15
  localparam int unsigned CoefW  = 32;   // Q16.16 coefficient
  localparam int unsigned OutW   = 36;   // Q20.16 result
  localparam int unsigned OrderW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FracShift = 15;
  localparam int unsigned NumStages = 4;

  localparam logic [CfgIdxW-1:0] RegOrder   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCoefC   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCoefX   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCoefY   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoefXX  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCoefXY  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCoefYY  = 3'd6;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [OutW-1:0]  acc_t;

  typedef struct packed {
    logic [OrderW-1:0] order;
    coef_t             c_const;
    coef_t             c_x;
    coef_t             c_y;
    coef_t             c_xx;
    coef_t             c_xy;
    coef_t             c_yy;
  } coef_set_t;

endpackage

// ----- design/bpe_power.sv -----
// first pipeline stage: coordinate capture and power products x*x, x*y, y*y
// depends on bpe_pkg

module bpe_power (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [bpe_pkg::CoordW-1:0]    x_i,
  input  logic signed [bpe_pkg::CoordW-1:0]    y_i,
  output logic signed [bpe_pkg::CoordW-1:0]    x_o,
  output logic signed [bpe_pkg::CoordW-1:0]    y_o,
  output logic signed [bpe_pkg::PowW-1:0]      pxx_o,
  output logic signed [bpe_pkg::PowW-1:0]      pxy_o,
  output logic signed [bpe_pkg::PowW-1:0]      pyy_o
);

  localparam int unsigned ProdW = 2 * bpe_pkg::CoordW;

  logic signed [ProdW-1:0] mxx, mxy, myy;
  logic signed [bpe_pkg::CoordW-1:0] x_q, y_q;
  logic signed [bpe_pkg::PowW-1:0] pxx_q, pxy_q, pyy_q;

  assign mxx = x_i * x_i;
  assign mxy = x_i * y_i;
  assign myy = y_i * y_i;

  // keeping the top bits is the floor shift by 15
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= x_i;
      y_q   <= y_i;
      pxx_q <= mxx[ProdW-1:bpe_pkg::FracShift];
      pxy_q <= mxy[ProdW-1:bpe_pkg::FracShift];
      pyy_q <= myy[ProdW-1:bpe_pkg::FracShift];
    end
  end

  assign x_o   = x_q;
  assign y_o   = y_q;
  assign pxx_o = pxx_q;
  assign pxy_o = pxy_q;
  assign pyy_o = pyy_q;

endmodule

// ----- design/bpe_term.sv -----
// second pipeline stage: coefficient times monomial, order masking
// depends on bpe_pkg

module bpe_term (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  bpe_pkg::coef_set_t                   coefs_i,
  input  logic signed [bpe_pkg::CoordW-1:0]    x_i,
  input  logic signed [bpe_pkg::CoordW-1:0]    y_i,
  input  logic signed [bpe_pkg::PowW-1:0]      pxx_i,
  input  logic signed [bpe_pkg::PowW-1:0]      pxy_i,
  input  logic signed [bpe_pkg::PowW-1:0]      pyy_i,
  output bpe_pkg::acc_t                        term_o [6]
);

  localparam int unsigned LinW  = bpe_pkg::CoefW + bpe_pkg::CoordW;
  localparam int unsigned QuadW = bpe_pkg::CoefW + bpe_pkg::PowW;
  localparam int unsigned LinTW  = LinW - bpe_pkg::FracShift;
  localparam int unsigned QuadTW = QuadW - bpe_pkg::FracShift;

  logic signed [LinW-1:0]  mx, my;
  logic signed [QuadW-1:0] mxx, mxy, myy;
  logic signed [LinTW-1:0]  tx, ty;
  logic signed [QuadTW-1:0] txx, txy, tyy;
  logic use_lin, use_quad;
  bpe_pkg::acc_t term_d [6];
  bpe_pkg::acc_t term_q [6];

  assign mx  = coefs_i.c_x  * x_i;
  assign my  = coefs_i.c_y  * y_i;
  assign mxx = coefs_i.c_xx * pxx_i;
  assign mxy = coefs_i.c_xy * pxy_i;
  assign myy = coefs_i.c_yy * pyy_i;

  assign tx  = mx[LinW-1:bpe_pkg::FracShift];
  assign ty  = my[LinW-1:bpe_pkg::FracShift];
  assign txx = mxx[QuadW-1:bpe_pkg::FracShift];
  assign txy = mxy[QuadW-1:bpe_pkg::FracShift];
  assign tyy = myy[QuadW-1:bpe_pkg::FracShift];

  // order three behaves as order two
  assign use_lin  = (coefs_i.order != '0);
  assign use_quad = coefs_i.order[1];

  always_comb begin
    term_d[0] = {{(bpe_pkg::OutW-bpe_pkg::CoefW){coefs_i.c_const[bpe_pkg::CoefW-1]}},
                 coefs_i.c_const};
    term_d[1] = use_lin  ? {{(bpe_pkg::OutW-LinTW){tx[LinTW-1]}}, tx}    : '0;
    term_d[2] = use_lin  ? {{(bpe_pkg::OutW-LinTW){ty[LinTW-1]}}, ty}    : '0;
    term_d[3] = use_quad ? {{(bpe_pkg::OutW-QuadTW){txx[QuadTW-1]}}, txx} : '0;
    term_d[4] = use_quad ? {{(bpe_pkg::OutW-QuadTW){txy[QuadTW-1]}}, txy} : '0;
    term_d[5] = use_quad ? {{(bpe_pkg::OutW-QuadTW){tyy[QuadTW-1]}}, tyy} : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

// ----- design/bpe_sum.sv -----
// third and fourth pipeline stages: two-level adder tree over the six terms
// depends on bpe_pkg

module bpe_sum (
  input  logic           clk_i,
  input  logic           en_pair_i,
  input  logic           en_out_i,
  input  bpe_pkg::acc_t  term_i [6],
  output bpe_pkg::acc_t  sum_o
);

  bpe_pkg::acc_t pair_q [3];
  bpe_pkg::acc_t sum_q;

  always_ff @(posedge clk_i) begin
    if (en_pair_i) begin
      pair_q[0] <= term_i[0] + term_i[1];
      pair_q[1] <= term_i[2] + term_i[3];
      pair_q[2] <= term_i[4] + term_i[5];
    end
  end

  // the true total always fits, so wrap-around in partial sums is harmless
  always_ff @(posedge clk_i) begin
    if (en_out_i) begin
      sum_q <= pair_q[0] + pair_q[1] + pair_q[2];
    end
  end

  assign sum_o = sum_q;

endmodule

// ----- design/bivariate_polynomial_eval_core.sv -----
// Evaluates c0 + cx*x + cy*y + cxx*x^2 + cxy*x*y + cyy*y^2 on a stream of signed Q1.15
// coordinate pairs and returns a signed Q20.16 value in 36 bits. The core is a four-stage
// pipeline (power products, coefficient products, pairwise sums, final sum) and takes one
// request every cycle unless stalled; a taken request passes the power, term, pair and sum
// registers in turn, and its result is held while the output is stalled. Each stage holds
// its item until the next stage has room, so bubbles close up and requests keep flowing while
// a result waits. The user must write coefficients and the order through the configuration
// port while no request is in flight; the core does not enforce this. Index 0 is the order,
// indexes 1 to 6 the coefficients of 1, x, y, x^2, xy, y^2, other indexes are ignored.
// depends on bpe_pkg, bpe_power, bpe_term, bpe_sum

module bivariate_polynomial_eval_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [bpe_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [bpe_pkg::CoefW-1:0]             cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [bpe_pkg::CoordW-1:0]     x_in_i,
  input  logic signed [bpe_pkg::CoordW-1:0]     y_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [bpe_pkg::OutW-1:0]       poly_value_o
);

  localparam int unsigned NS = bpe_pkg::NumStages;

  bpe_pkg::coef_set_t coefs_q;
  logic [NS-1:0] valid_q, valid_d;
  logic [NS-1:0] en;

  logic signed [bpe_pkg::CoordW-1:0] x1, y1;
  logic signed [bpe_pkg::PowW-1:0]   pxx1, pxy1, pyy1;
  bpe_pkg::acc_t term2 [6];
  bpe_pkg::acc_t sum4;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpe_pkg::RegOrder:  coefs_q.order   <= cfg_data_i[bpe_pkg::OrderW-1:0];
        bpe_pkg::RegCoefC:  coefs_q.c_const <= cfg_data_i;
        bpe_pkg::RegCoefX:  coefs_q.c_x     <= cfg_data_i;
        bpe_pkg::RegCoefY:  coefs_q.c_y     <= cfg_data_i;
        bpe_pkg::RegCoefXX: coefs_q.c_xx    <= cfg_data_i;
        bpe_pkg::RegCoefXY: coefs_q.c_xy    <= cfg_data_i;
        bpe_pkg::RegCoefYY: coefs_q.c_yy    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a stage may load when it is empty or its successor loads too
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) valid_d[0] = in_valid_i;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  bpe_power u_power (
    .clk_i (clk_i),
    .en_i  (en[0]),
    .x_i   (x_in_i),
    .y_i   (y_in_i),
    .x_o   (x1),
    .y_o   (y1),
    .pxx_o (pxx1),
    .pxy_o (pxy1),
    .pyy_o (pyy1)
  );

  bpe_term u_term (
    .clk_i   (clk_i),
    .en_i    (en[1]),
    .coefs_i (coefs_q),
    .x_i     (x1),
    .y_i     (y1),
    .pxx_i   (pxx1),
    .pxy_i   (pxy1),
    .pyy_i   (pyy1),
    .term_o  (term2)
  );

  bpe_sum u_sum (
    .clk_i     (clk_i),
    .en_pair_i (en[2]),
    .en_out_i  (en[3]),
    .term_i    (term2),
    .sum_o     (sum4)
  );

  assign in_stall_o   = !en[0];
  assign out_valid_o  = valid_q[NS-1];
  assign poly_value_o = sum4;

endmodule

// ----- design/bpe_checker.sv -----
// port-level checks for the evaluator core, attached by bind
// depends on bpe_pkg and bivariate_polynomial_eval_core

module bpe_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [bpe_pkg::OutW-1:0]          poly_value_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(poly_value_o))
    else $error("stalled result changed");

  // back-pressure only when the pipeline is full and the output is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // a taken request reaches the output if the output is not stalled meanwhile
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
    |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind bivariate_polynomial_eval_core bpe_checker u_bpe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .poly_value_o (poly_value_o)
);
